[hw/rtl/hmsb_pkg.sv]
// types and codes for the hash multiset bucket table
// no dependencies

package hmsb_pkg;

   localparam int OP_WIDTH = 3;
   localparam int REQ_KEY_WIDTH = 32;
   localparam int CSR_WIDTH = 7;
   localparam int MCOUNT_WIDTH = 4;
   localparam int TOTAL_OUT_WIDTH = 10;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 7'd10;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT    = 3'd0,
      OP_COUNT     = 3'd1,
      OP_ERASE_ONE = 3'd2,
      OP_ERASE_ALL = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_SWEEP = 5'b10000
   } state_type;

endpackage

[hw/rtl/hmsb_mod.sv]
// restoring remainder unit, one dividend bit per cycle
// no dependencies

module hmsb_mod #(
   parameter int KEY_WIDTH = 32,
   parameter int DIV_WIDTH = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] remainder
);

   localparam int CNT_WIDTH = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [KEY_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0] div_ff, div_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[KEY_WIDTH-1]};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DIV_WIDTH-1:0];
         end
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(KEY_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/hash_multiset_bucket_table.sv]
// hash multiset bucket table: each word passes the bit-serial remainder unit,
// then one bucket row read and one write-back.
// one word in flight: no new word is taken until the last is through; a result waits in the output reg.
// a clear word adds a sweep over all NUM_BUCKETS rows of the valid memory, stall held high.
// synchronous reset runs the same sweep before the first word is taken.
// depends on hmsb_pkg and hmsb_mod

module hash_multiset_bucket_table
   import hmsb_pkg::*;
#(
   parameter int NUM_BUCKETS  = 64,
   parameter int BUCKET_SLOTS = 8,
   parameter int KEY_WIDTH    = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_WIDTH-1:0]        req_operation,
   input  logic [REQ_KEY_WIDTH-1:0]   req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic                       rsp_success,
   output logic [MCOUNT_WIDTH-1:0]    rsp_match_count,
   output logic [TOTAL_OUT_WIDTH-1:0] rsp_total_elements,
   output logic                       rsp_is_empty,
   input  logic                       csr_wr_en,
   input  logic [CSR_WIDTH-1:0]       csr_wr_data
);

   localparam int BW  = $clog2(NUM_BUCKETS);
   localparam int NBW = $clog2(NUM_BUCKETS + 1);
   localparam int TW  = $clog2(NUM_BUCKETS * BUCKET_SLOTS + 1);
   localparam int CW  = $clog2(BUCKET_SLOTS + 1);

   typedef logic [BUCKET_SLOTS-1:0][KEY_WIDTH-1:0] key_row_type;
   typedef logic [BUCKET_SLOTS-1:0]                vld_row_type;

   key_row_type key_mem [NUM_BUCKETS];
   vld_row_type vld_mem [NUM_BUCKETS];

   state_type             state_ff, state_in;
   logic [CSR_WIDTH-1:0]  csr_ff, csr_in;
   logic [OP_WIDTH-1:0]   op_ff, op_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [BW-1:0]         bucket_ff, bucket_in;
   logic [BW-1:0]         sweep_ff, sweep_in;
   logic [TW-1:0]         total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic                  success_ff, success_in;
   logic [MCOUNT_WIDTH-1:0] mcount_ff, mcount_in;
   logic [TW-1:0]         rtotal_ff, rtotal_in;

   key_row_type rd_key_ff;
   vld_row_type rd_vld_ff;

   logic [63:0]          key_wide;
   logic [31:0]          nb_wide;
   logic [NBW-1:0]       nb;
   logic                 div_start, div_done;
   logic [NBW-1:0]       div_rem;
   logic                 accept, commit;
   vld_row_type          match, free, low_free, low_match;
   logic [CW-1:0]        hit_count;
   logic                 vld_we, key_we;
   logic [BW-1:0]        vld_addr;
   vld_row_type          vld_wdata;
   key_row_type          key_wdata;

   assign key_wide = {32'b0, req_key};

   always_comb begin
      nb_wide = {{(32 - CSR_WIDTH){1'b0}}, csr_ff};
      if (nb_wide == 32'd0) begin
         nb_wide = 32'd1;
      end else if (nb_wide > 32'(NUM_BUCKETS)) begin
         nb_wide = 32'(NUM_BUCKETS);
      end
      nb = nb_wide[NBW-1:0];
   end

   assign accept    = req_valid && !req_stall;
   assign div_start = accept;

   hmsb_mod #(
      .KEY_WIDTH (KEY_WIDTH),
      .DIV_WIDTH (NBW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (key_in),
      .divisor   (nb),
      .done      (div_done),
      .remainder (div_rem)
   );

   // bucket row compare
   always_comb begin
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         match[i] = rd_vld_ff[i] && (rd_key_ff[i] == key_ff);
      end
      free      = ~rd_vld_ff;
      low_free  = free & (~free + 1'b1);
      low_match = match & (~match + 1'b1);
      hit_count = CW'($countones(match));
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         key_wdata[i] = low_free[i] ? key_ff : rd_key_ff[i];
      end
   end

   assign commit = (state_ff == ST_EVAL) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_wr_en ? csr_wr_data : csr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      sweep_in     = sweep_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      success_in   = success_ff;
      mcount_in    = mcount_ff;
      rtotal_in    = rtotal_ff;
      vld_we       = 1'b0;
      key_we       = 1'b0;
      vld_addr     = bucket_ff;
      vld_wdata    = rd_vld_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               key_in   = key_wide[KEY_WIDTH-1:0];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               bucket_in = div_rem[BW-1:0];
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               success_in   = 1'b0;
               mcount_in    = '0;
               state_in     = ST_IDLE;
               unique case (op_ff)
                  OP_INSERT: begin
                     found_in = hit_count != '0;
                     if (free != '0) begin
                        success_in = 1'b1;
                        vld_we     = 1'b1;
                        key_we     = 1'b1;
                        vld_wdata  = rd_vld_ff | low_free;
                        total_in   = total_ff + 1'b1;
                     end
                  end
                  OP_COUNT: begin
                     found_in   = hit_count != '0;
                     success_in = 1'b1;
                     mcount_in  = MCOUNT_WIDTH'(hit_count);
                  end
                  OP_ERASE_ONE: begin
                     found_in = hit_count != '0;
                     if (hit_count != '0) begin
                        success_in = 1'b1;
                        vld_we     = 1'b1;
                        vld_wdata  = rd_vld_ff & ~low_match;
                        total_in   = total_ff - 1'b1;
                     end
                  end
                  OP_ERASE_ALL: begin
                     found_in   = hit_count != '0;
                     success_in = hit_count != '0;
                     mcount_in  = MCOUNT_WIDTH'(hit_count);
                     vld_we     = 1'b1;
                     vld_wdata  = rd_vld_ff & ~match;
                     total_in   = total_ff - TW'(hit_count);
                  end
                  OP_CLEAR: begin
                     success_in = 1'b1;
                     total_in   = '0;
                     sweep_in   = '0;
                     state_in   = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
               rtotal_in = total_in;
            end
         end
         ST_SWEEP: begin
            vld_we    = 1'b1;
            vld_addr  = sweep_ff;
            vld_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         csr_ff       <= CSR_RESET;
         sweep_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         sweep_ff     <= sweep_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      bucket_ff  <= bucket_in;
      found_ff   <= found_in;
      success_ff <= success_in;
      mcount_ff  <= mcount_in;
      rtotal_ff  <= rtotal_in;
   end

   // bucket memories, one row per bucket
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[bucket_ff] <= key_wdata;
      end
      rd_key_ff <= key_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (vld_we) begin
         vld_mem[vld_addr] <= vld_wdata;
      end
      rd_vld_ff <= vld_mem[bucket_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_success        = success_ff;
   assign rsp_match_count    = mcount_ff;
   assign rsp_total_elements = TOTAL_OUT_WIDTH'(rtotal_ff);
   assign rsp_is_empty       = rtotal_ff == '0;

endmodule

[hw/rtl/hmsb_chk.sv]
// port-level checks for the hash multiset bucket table
// bound to hash_multiset_bucket_table, no package use

module hmsb_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_operation,
   input logic [31:0] req_key,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic        rsp_success,
   input logic [3:0]  rsp_match_count,
   input logic [9:0]  rsp_total_elements,
   input logic        rsp_is_empty,
   input logic        csr_wr_en,
   input logic [6:0]  csr_wr_data
);

   // word held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // sweep after reset blocks input
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken during reset sweep");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_total_elements == 10'd0)
      else $error("empty flag with nonzero total");

   a_count_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_found || !rsp_success) |-> rsp_match_count == 4'd0)
      else $error("match count without match");

endmodule

bind hash_multiset_bucket_table hmsb_chk u_hmsb_chk (.*);
